>>> rtl/sll_pkg.sv
// ----------------------------------------------------------------------------
// Shell line lexer package
// Result record, token kind codes, character codes and character classes
// shared by the lexer core and the top level.
// ----------------------------------------------------------------------------
package sll_pkg;

  // Token kinds carried on a token end mark.
  localparam logic [2:0] KIND_WORD     = 3'd0;
  localparam logic [2:0] KIND_STRING   = 3'd1;
  localparam logic [2:0] KIND_PIPE     = 3'd2;
  localparam logic [2:0] KIND_REDIR_R  = 3'd3;
  localparam logic [2:0] KIND_REDIR_L  = 3'd4;
  localparam logic [2:0] KIND_OTHER_OP = 3'd5;

  // Character codes.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  // Depth of the result queue and width of its pointers.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;

  // One result item.
  typedef struct packed {
    logic       has_char;
    logic [7:0] char_value;
    logic       token_end;
    logic [2:0] token_kind;
    logic       unterminated;
    logic       last_result;
  } result_t;

  // Separator characters.
  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  // Operator characters.
  function automatic logic is_op(input logic [7:0] c);
    return (c == CH_PIPE) || (c == CH_GT) || (c == CH_LT) || (c == CH_AMP);
  endfunction

  // Kind of a single-character operator token.
  function automatic logic [2:0] op_kind(input logic [7:0] c);
    logic [2:0] k;
    k = KIND_OTHER_OP;
    if (c == CH_PIPE) begin
      k = KIND_PIPE;
    end else if (c == CH_GT) begin
      k = KIND_REDIR_R;
    end else if (c == CH_LT) begin
      k = KIND_REDIR_L;
    end
    return k;
  endfunction

  // Builds a result with unused fields held at zero.
  function automatic result_t make_res(input logic has, input logic [7:0] ch,
                                       input logic fin, input logic [2:0] kind,
                                       input logic unterm);
    result_t r;
    r.has_char     = has;
    r.char_value   = has ? ch : 8'd0;
    r.token_end    = fin;
    r.token_kind   = fin ? kind : KIND_WORD;
    r.unterminated = unterm;
    r.last_result  = 1'b0;
    return r;
  endfunction

endpackage

>>> rtl/sll_if.sv
// ----------------------------------------------------------------------------
// Shell line lexer channels
// Valid/ready channels for input characters and for result items.
// ----------------------------------------------------------------------------
interface sll_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       line_end;

  modport source (output valid, char_in, line_end, input ready);
  modport sink   (input valid, char_in, line_end, output ready);
endinterface

interface sll_out_if;
  logic       valid;
  logic       ready;
  logic       has_char;
  logic [7:0] char_value;
  logic       token_end;
  logic [2:0] token_kind;
  logic       unterminated;
  logic       last_result;

  modport source (output valid, has_char, char_value, token_end, token_kind,
                  unterminated, last_result, input ready);
  modport sink   (input valid, has_char, char_value, token_end, token_kind,
                  unterminated, last_result, output ready);
endinterface

>>> rtl/shell_line_lexer.sv
// A result item enters the result queue when its character is accepted and is offered on
// the output once the items ahead of it have been taken. One character per cycle while
// each character yields at most one result item and the output does not stall; the
// four-entry result queue takes a character only while it has room for two result items.
// Reset (synchronous, active high) clears the lexer state and empties the result queue.
// ----------------------------------------------------------------------------
// Shell line lexer
// Streams token characters and token end marks from a command line that
// arrives one character per item.
// ----------------------------------------------------------------------------
module shell_line_lexer (
  input logic       clk,
  input logic       rst,
  sll_in_if.sink    line_in,
  sll_out_if.source token_out
);
  import sll_pkg::*;

  logic               in_acc;
  logic               pop;
  logic [1:0]         push_n;
  result_t            res_a, res_b;
  result_t            queue [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QPTR_W:0]    count, count_next;
  result_t            head;

  // Room for two more result items is needed before a character is taken.
  assign line_in.ready = (count <= 3'(QDEPTH - 2));
  assign in_acc        = line_in.valid && line_in.ready;

  sll_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_acc),
    .char_in   (line_in.char_in),
    .line_end  (line_in.line_end),
    .res_count (push_n),
    .res_a     (res_a),
    .res_b     (res_b)
  );

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (in_acc && (push_n != 2'd0)) begin
      queue[wr_ptr] <= res_a;
    end
    if (in_acc && (push_n == 2'd2)) begin
      queue[wr_ptr + 1'b1] <= res_b;
    end
  end

  // Queue pointers and fill count.
  assign pop        = token_out.valid && token_out.ready;
  assign count_next = count + (in_acc ? {1'b0, push_n} : 3'd0) - {2'b00, pop};

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_acc) begin
        wr_ptr <= wr_ptr + push_n;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count_next;
    end
  end

  // Output side reads the head of the queue.
  assign head                   = queue[rd_ptr];
  assign token_out.valid        = (count != '0);
  assign token_out.has_char     = head.has_char;
  assign token_out.char_value   = head.char_value;
  assign token_out.token_end    = head.token_end;
  assign token_out.token_kind   = head.token_kind;
  assign token_out.unterminated = head.unterminated;
  assign token_out.last_result  = head.last_result;

  // The queue never holds more items than it has entries.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(QDEPTH))
    else $error("result queue overflow");

  // Of two results from one character, only the second closes the item.
  a_last_order: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (push_n == 2'd2)) |-> (!res_a.last_result && res_b.last_result))
    else $error("last_result on the wrong result");

  // A single result from one character always closes the item.
  a_last_single: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (push_n == 2'd1)) |-> res_a.last_result)
    else $error("single result lacks last_result");

  // On a push without a pop, the fill count grows by the items pushed.
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !pop) |=> (count == $past(count) + {1'b0, $past(push_n)}))
    else $error("result queue count mismatch");

endmodule

>>> rtl/sll_core.sv
// ----------------------------------------------------------------------------
// Shell line lexer core
// Holds the lexer state and works out, combinationally, the zero, one or two
// result items that an accepted character causes.
// ----------------------------------------------------------------------------
module sll_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       char_in,
  input  logic             line_end,
  output logic [1:0]       res_count,
  output sll_pkg::result_t res_a,
  output sll_pkg::result_t res_b
);
  import sll_pkg::*;

  // Lexer state.
  logic       quote_mode,      quote_mode_next;
  logic       pend_valid,      pend_valid_next;
  logic [7:0] pend_char,       pend_char_next;
  logic       token_open,      token_open_next;
  logic       token_string,    token_string_next;

  logic       consumed;
  logic [1:0] cnt;
  logic [2:0] close_kind;
  logic [2:0] end_kind;
  logic       end_unterm;
  result_t    res_arr [2];

  // Next state and results for the character on the input.
  always_comb begin
    quote_mode_next   = quote_mode;
    pend_valid_next   = pend_valid;
    pend_char_next    = pend_char;
    token_open_next   = token_open;
    token_string_next = token_string;
    consumed          = 1'b0;
    cnt               = 2'd0;
    res_arr[0]        = '0;
    res_arr[1]        = '0;
    close_kind        = token_string ? KIND_STRING : KIND_WORD;

    // A waiting operator either doubles up or is closed on its own.
    if (pend_valid) begin
      if (!quote_mode && (char_in == pend_char)) begin
        res_arr[0] = make_res(1'b1, char_in, 1'b1, KIND_OTHER_OP, 1'b0);
        consumed   = 1'b1;
      end else begin
        res_arr[0] = make_res(1'b0, 8'd0, 1'b1, op_kind(pend_char), 1'b0);
      end
      cnt             = 2'd1;
      pend_valid_next = 1'b0;
      pend_char_next  = 8'd0;
    end

    // Classify the character.
    if (!consumed) begin
      if (quote_mode) begin
        if (char_in == CH_QUOTE) begin
          if (token_open) begin
            res_arr[cnt[0]] = make_res(1'b0, 8'd0, 1'b1, KIND_STRING, 1'b0);
            cnt             = cnt + 2'd1;
          end
          token_open_next   = 1'b0;
          token_string_next = 1'b0;
          quote_mode_next   = 1'b0;
        end else begin
          res_arr[cnt[0]] = make_res(1'b1, char_in, 1'b0, KIND_WORD, 1'b0);
          cnt             = cnt + 2'd1;
          token_open_next = 1'b1;
        end
      end else if (is_sep(char_in)) begin
        if (token_open) begin
          res_arr[cnt[0]] = make_res(1'b0, 8'd0, 1'b1, close_kind, 1'b0);
          cnt             = cnt + 2'd1;
        end
        token_open_next   = 1'b0;
        token_string_next = 1'b0;
      end else if (is_op(char_in)) begin
        if (token_open) begin
          res_arr[cnt[0]] = make_res(1'b0, 8'd0, 1'b1, close_kind, 1'b0);
          cnt             = cnt + 2'd1;
        end
        token_open_next   = 1'b0;
        token_string_next = 1'b0;
        res_arr[cnt[0]]   = make_res(1'b1, char_in, 1'b0, KIND_WORD, 1'b0);
        cnt               = cnt + 2'd1;
        pend_valid_next   = 1'b1;
        pend_char_next    = char_in;
      end else if (char_in == CH_QUOTE) begin
        quote_mode_next   = 1'b1;
        token_string_next = 1'b1;
      end else begin
        res_arr[cnt[0]] = make_res(1'b1, char_in, 1'b0, KIND_WORD, 1'b0);
        cnt             = cnt + 2'd1;
        token_open_next = 1'b1;
      end
    end

    // At line end the open token closes, on the last result if it is free.
    end_kind   = pend_valid_next ? op_kind(pend_char_next)
               : (token_string_next ? KIND_STRING : KIND_WORD);
    end_unterm = quote_mode_next && token_open_next;
    if (line_end) begin
      if (pend_valid_next || token_open_next) begin
        if ((cnt != 2'd0) && !res_arr[cnt[0] - 1'b1].token_end) begin
          res_arr[cnt[0] - 1'b1].token_end    = 1'b1;
          res_arr[cnt[0] - 1'b1].token_kind   = end_kind;
          res_arr[cnt[0] - 1'b1].unterminated = end_unterm;
        end else begin
          res_arr[cnt[0]] = make_res(1'b0, 8'd0, 1'b1, end_kind, end_unterm);
          cnt             = cnt + 2'd1;
        end
      end
      quote_mode_next   = 1'b0;
      pend_valid_next   = 1'b0;
      pend_char_next    = 8'd0;
      token_open_next   = 1'b0;
      token_string_next = 1'b0;
    end

    // Mark the final result of this item.
    if (cnt != 2'd0) begin
      res_arr[cnt[0] - 1'b1].last_result = 1'b1;
    end
  end

  // State update on each accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      quote_mode   <= 1'b0;
      pend_valid   <= 1'b0;
      pend_char    <= 8'd0;
      token_open   <= 1'b0;
      token_string <= 1'b0;
    end else if (accept) begin
      quote_mode   <= quote_mode_next;
      pend_valid   <= pend_valid_next;
      pend_char    <= pend_char_next;
      token_open   <= token_open_next;
      token_string <= token_string_next;
    end
  end

  assign res_count = cnt;
  assign res_a     = res_arr[0];
  assign res_b     = res_arr[1];

endmodule

>>> sim/sll_token_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token stream checker for the shell line lexer
// Watches the character and token channels, predicts the token items that
// each accepted character gives rise to, and compares every accepted token
// item with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module sll_token_checker (
  input  logic clk,
  input  logic rst,
  sll_in_if    line_mon,
  sll_out_if   tok_mon,
  output int   fail_count,
  output int   expect_left
);
  import sll_pkg::*;

  // Lexer state as the checker sees it.
  logic       quoted;
  logic       op_wait;
  logic [7:0] op_byte;
  logic       tok_open;
  logic       tok_is_str;

  result_t predicted_tokens[$];
  int      errors;

  function automatic logic is_blank(input logic [7:0] c);
    case (c)
      CH_SPACE, CH_TAB, CH_CR, CH_LF: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic is_op_byte(input logic [7:0] c);
    case (c)
      CH_PIPE, CH_GT, CH_LT, CH_AMP: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Kind of a token made of one operator character.
  function automatic logic [2:0] single_op_kind(input logic [7:0] c);
    case (c)
      CH_PIPE: return KIND_PIPE;
      CH_GT:   return KIND_REDIR_R;
      CH_LT:   return KIND_REDIR_L;
      default: return KIND_OTHER_OP;
    endcase
  endfunction

  // One token item, with fields that carry nothing held at zero.
  function automatic result_t token_item(input logic has, input logic [7:0] ch,
                                         input logic fin, input logic [2:0] kind,
                                         input logic unterm);
    result_t r;
    r.has_char     = has;
    r.char_value   = has ? ch : 8'h00;
    r.token_end    = fin;
    r.token_kind   = fin ? kind : KIND_WORD;
    r.unterminated = unterm;
    r.last_result  = 1'b0;
    return r;
  endfunction

  // Lexes one character and queues the token items it gives rise to.
  function automatic void lex_char(input logic [7:0] c, input logic fin);
    result_t    res [0:2];
    int         n;
    logic       used;
    logic [2:0] kind;
    logic       unterm;
    n    = 0;
    used = 1'b0;

    // A pending operator either doubles up or closes on its own.
    if (op_wait) begin
      if (!quoted && c == op_byte) begin
        res[n] = token_item(1'b1, c, 1'b1, KIND_OTHER_OP, 1'b0);
        used   = 1'b1;
      end else begin
        res[n] = token_item(1'b0, 8'h00, 1'b1, single_op_kind(op_byte), 1'b0);
      end
      n++;
      op_wait = 1'b0;
      op_byte = 8'h00;
    end

    if (!used) begin
      if (quoted) begin
        // Inside quotes everything but the quote is a string character.
        if (c == CH_QUOTE) begin
          if (tok_open) begin
            res[n] = token_item(1'b0, 8'h00, 1'b1, KIND_STRING, 1'b0);
            n++;
          end
          tok_open   = 1'b0;
          tok_is_str = 1'b0;
          quoted     = 1'b0;
        end else begin
          res[n] = token_item(1'b1, c, 1'b0, KIND_WORD, 1'b0);
          n++;
          tok_open = 1'b1;
        end
      end else if (is_blank(c) || is_op_byte(c)) begin
        if (tok_open) begin
          res[n] = token_item(1'b0, 8'h00, 1'b1,
                              tok_is_str ? KIND_STRING : KIND_WORD, 1'b0);
          n++;
        end
        tok_open   = 1'b0;
        tok_is_str = 1'b0;
        if (is_op_byte(c)) begin
          res[n] = token_item(1'b1, c, 1'b0, KIND_WORD, 1'b0);
          n++;
          op_wait = 1'b1;
          op_byte = c;
        end
      end else if (c == CH_QUOTE) begin
        quoted     = 1'b1;
        tok_is_str = 1'b1;
      end else begin
        res[n] = token_item(1'b1, c, 1'b0, KIND_WORD, 1'b0);
        n++;
        tok_open = 1'b1;
      end
    end

    // The end of the line closes whatever is open, folding the end mark into
    // the last item where that item does not already close a token.
    if (fin) begin
      if (op_wait || tok_open) begin
        kind   = op_wait ? single_op_kind(op_byte)
               : (tok_is_str ? KIND_STRING : KIND_WORD);
        unterm = quoted && tok_open;
        if (n > 0 && !res[n-1].token_end) begin
          res[n-1].token_end    = 1'b1;
          res[n-1].token_kind   = kind;
          res[n-1].unterminated = unterm;
        end else begin
          res[n] = token_item(1'b0, 8'h00, 1'b1, kind, unterm);
          n++;
        end
      end
      quoted     = 1'b0;
      op_wait    = 1'b0;
      op_byte    = 8'h00;
      tok_open   = 1'b0;
      tok_is_str = 1'b0;
    end

    if (n > 0) begin
      res[n-1].last_result = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      predicted_tokens.push_back(res[i]);
    end
  endfunction

  // Prediction on each accepted character, comparison on each accepted item.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      quoted     = 1'b0;
      op_wait    = 1'b0;
      op_byte    = 8'h00;
      tok_open   = 1'b0;
      tok_is_str = 1'b0;
      predicted_tokens.delete();
      errors     = 0;
    end else begin
      if (line_mon.valid && line_mon.ready) begin
        lex_char(line_mon.char_in, line_mon.line_end);
      end
      if (tok_mon.valid && tok_mon.ready) begin
        got.has_char     = tok_mon.has_char;
        got.char_value   = tok_mon.char_value;
        got.token_end    = tok_mon.token_end;
        got.token_kind   = tok_mon.token_kind;
        got.unterminated = tok_mon.unterminated;
        got.last_result  = tok_mon.last_result;
        if (predicted_tokens.size() == 0) begin
          errors++;
          $display("%0t: unexpected item has=%0b ch=%02h end=%0b kind=%0d unt=%0b last=%0b",
                   $time, got.has_char, got.char_value, got.token_end,
                   got.token_kind, got.unterminated, got.last_result);
        end else begin
          want = predicted_tokens.pop_front();
          if (got.has_char !== want.has_char || got.char_value !== want.char_value ||
              got.token_end !== want.token_end || got.token_kind !== want.token_kind ||
              got.unterminated !== want.unterminated ||
              got.last_result !== want.last_result) begin
            errors++;
            $display("%0t: mismatch expected has=%0b ch=%02h end=%0b kind=%0d unt=%0b last=%0b",
                     $time, want.has_char, want.char_value, want.token_end,
                     want.token_kind, want.unterminated, want.last_result);
            $display("%0t:            actual has=%0b ch=%02h end=%0b kind=%0d unt=%0b last=%0b",
                     $time, got.has_char, got.char_value, got.token_end,
                     got.token_kind, got.unterminated, got.last_result);
          end
        end
      end
    end
    fail_count  <= errors;
    expect_left <= predicted_tokens.size();
  end

endmodule

>>> sim/tb_shell_line_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shell line lexer testbench
// Feeds command lines one character per item, first a few hand-picked lines
// and then random ones, with random gaps and stalls on both channels. A
// checker beside the lexer predicts and compares the token items.
// ----------------------------------------------------------------------------
module tb_shell_line_lexer;
  import sll_pkg::*;

  logic       clk;
  logic       rst;
  int         fail_count;
  int         expect_left;
  int         sent;
  int         burst_left;
  logic       quiet;
  logic       rx_hold;
  logic [7:0] line_q[$];

  sll_in_if  line_in ();
  sll_out_if token_out ();

  shell_line_lexer u_top (
    .clk       (clk),
    .rst       (rst),
    .line_in   (line_in),
    .token_out (token_out)
  );

  sll_token_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .line_mon    (line_in),
    .tok_mon     (token_out),
    .fail_count  (fail_count),
    .expect_left (expect_left)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one character item and returns once it has been accepted.
  task automatic send_char(input logic [7:0] c, input logic fin);
    int gap;
    gap = (quiet || burst_left > 0) ? 0 : $urandom_range(0, 15);
    if (burst_left > 0) begin
      burst_left--;
    end
    if (gap > 0) begin
      line_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    line_in.valid    <= 1'b1;
    line_in.char_in  <= c;
    line_in.line_end <= fin;
    do @(posedge clk); while (!line_in.ready);
    sent++;
  endtask

  // Sends a whole line, marking its final character.
  task automatic send_line(input logic [7:0] chars[$]);
    for (int i = 0; i < chars.size(); i++) begin
      send_char(chars[i], i == chars.size() - 1);
    end
  endtask

  // Holds the character channel idle until every predicted item has come.
  task automatic drain;
    line_in.valid <= 1'b0;
    @(posedge clk);
    wait (expect_left == 0);
    @(posedge clk);
  endtask

  // Random character, weighted towards the classes the lexer cares about.
  function automatic logic [7:0] pick_char();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 35) begin
      return 8'h61 + 8'($urandom_range(0, 25));
    end else if (sel < 50) begin
      case ($urandom_range(0, 3))
        0: return CH_SPACE;
        1: return CH_TAB;
        2: return CH_CR;
        default: return CH_LF;
      endcase
    end else if (sel < 68) begin
      case ($urandom_range(0, 3))
        0: return CH_PIPE;
        1: return CH_GT;
        2: return CH_LT;
        default: return CH_AMP;
      endcase
    end else if (sel < 80) begin
      return CH_QUOTE;
    end else begin
      return 8'($urandom_range(0, 255));
    end
  endfunction

  // Token side: a random stall before each item, and one long hold-off on request.
  initial begin
    int stall;
    token_out.ready = 1'b0;
    forever begin
      if (rx_hold) begin
        rx_hold = 1'b0;
        stall   = 200;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 15);
      end
      if (stall > 0) begin
        token_out.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      token_out.ready <= 1'b1;
      do @(posedge clk); while (!token_out.valid);
    end
  end

  // Character side: reset, directed lines, random lines, then the verdict.
  initial begin
    int   len;
    logic held;
    logic paused;
    logic [7:0] c;
    rst              = 1'b1;
    line_in.valid    = 1'b0;
    line_in.char_in  = 8'h00;
    line_in.line_end = 1'b0;
    sent       = 0;
    burst_left = 0;
    quiet      = 1'b0;
    rx_hold    = 1'b0;
    held       = 1'b0;
    paused     = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extreme bytes as words, a doubled operator, an operator closed by
    // another, and a line ending on a word right after an operator.
    line_q = '{8'h00, CH_PIPE, CH_PIPE, CH_AMP, CH_LT, 8'hFF};
    send_line(line_q);
    // A quote in mid-word, quoted separators and operators, an empty string
    // and a final operator character.
    line_q = '{8'h61, CH_QUOTE, CH_SPACE, CH_GT, CH_QUOTE, CH_TAB, CH_QUOTE, CH_QUOTE, CH_GT};
    send_line(line_q);
    // A lone quote at the end of a line.
    line_q = '{CH_QUOTE};
    send_line(line_q);
    // A string still open at the end of the line.
    line_q = '{CH_LF, CH_QUOTE, 8'h78, CH_PIPE};
    send_line(line_q);
    // An operator closed by a separator, then a final quote.
    line_q = '{CH_AMP, CH_CR, CH_QUOTE};
    send_line(line_q);

    // Random lines with mostly short lengths and the odd long one.
    while (sent < 1300) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      line_q.delete();
      while (line_q.size() < len) begin
        c = pick_char();
        line_q.push_back(c);
        if ((c == CH_PIPE || c == CH_GT || c == CH_LT || c == CH_AMP) &&
            $urandom_range(0, 2) == 0 && line_q.size() < len) begin
          line_q.push_back(c);
        end
      end
      quiet = ($urandom_range(0, 4) == 0);

      // Once, the token side holds off while characters keep coming.
      if (!held && sent >= 400) begin
        held       = 1'b1;
        rx_hold    = 1'b1;
        burst_left = 60;
      end
      // Once, the character side waits until the lexer has fully drained.
      if (!paused && sent >= 800) begin
        paused = 1'b1;
        drain();
      end
      send_line(line_q);
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && expect_left == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog against a stalled handshake.
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> files.f
rtl/sll_pkg.sv
rtl/sll_if.sv
rtl/sll_core.sv
rtl/shell_line_lexer.sv
sim/sll_token_checker.sv
sim/tb_shell_line_lexer.sv
